// File: rtl/fbpa_pkg.sv
// Shared constants, codes and types of the fixed block pool allocator.
`timescale 1ns / 1ps

package fbpa_pkg;

	localparam int BLOCK_COUNT = 16;
	localparam int BLOCK_BYTES = 64;

	localparam int IDX_W  = $clog2(BLOCK_COUNT);
	localparam int OFS_W  = $clog2(BLOCK_BYTES);
	localparam int SIZE_W = $clog2(BLOCK_BYTES + 1);
	localparam int CNT_W  = $clog2(BLOCK_COUNT + 1);

	localparam int REQ_SIZE_W = 16;
	localparam int ADDR_W     = 16;
	localparam int BADDR_W    = 10;

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_QUERY = 2'd2,
		REQ_NONE  = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_ZERO    = 3'd1,
		ST_LARGE   = 3'd2,
		ST_FULL    = 3'd3,
		ST_NULL    = 3'd4,
		ST_FREED   = 3'd5,
		ST_BADADDR = 3'd6,
		ST_SPARE   = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} fsm_t;

endpackage

// File: rtl/fbpa_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator.
//
// Requests enter on the s_ group: tuser carries the request kind (allocate,
// free by address, query by address), tdata the size, address and null flag.
// Each request gives exactly one result beat on the m_ group: tuser carries
// the status, tdata the block index, block address, used mark, stored size
// and the used-block count after the request.
// A request passes through S_IDLE and S_EXEC: the accept decodes the address and reads
// the size RAM, then S_EXEC finds the lowest free block, writes the RAM
// and loads the output register. The result is registered and is valid once
// S_EXEC commits, and a new request is taken only after the last one commits.
// The output register parts the two sides: a new request is accepted while
// a result waits; if the receiver still stalls when the next result is
// ready, that request holds in S_EXEC and input stalls.
// Reset empties the pool at once: used marks live in flops and gate the
// size RAM, so no clearing pass is needed.
`timescale 1ns / 1ps

module fixed_block_pool_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // req_size[15:0], target_addr[31:16], addr_is_null[32]
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // block_index[3:0], block_addr[13:4], block_used[14],
	                              // block_req_size[21:15], blocks_in_use[26:22]
	output logic [2:0]  m_tuser   // status[2:0]
);

	fbpa_pkg::fsm_t state_q;

	logic [fbpa_pkg::REQ_SIZE_W-1:0] in_size;
	logic [fbpa_pkg::ADDR_W-1:0]     in_addr;
	logic                            in_null;
	logic                            accept;

	fbpa_pkg::status_t           map_status;
	logic [fbpa_pkg::IDX_W-1:0]  map_idx;
	logic [fbpa_pkg::ADDR_W-fbpa_pkg::OFS_W-1:0] addr_hi;

	fbpa_pkg::req_type_t             type_s1;
	logic [fbpa_pkg::REQ_SIZE_W-1:0] size_s1;
	fbpa_pkg::status_t               map_status_s1;
	logic [fbpa_pkg::IDX_W-1:0]      map_idx_s1;

	logic [fbpa_pkg::BLOCK_COUNT-1:0] marks_q;
	logic [fbpa_pkg::CNT_W-1:0]       total_q;
	logic [fbpa_pkg::SIZE_W-1:0]      ram_rdata;

	logic                        free_found;
	logic [fbpa_pkg::IDX_W-1:0]  free_idx;
	fbpa_pkg::status_t           res_status;
	logic [fbpa_pkg::IDX_W-1:0]  res_idx;
	logic                        res_named;
	logic                        res_used;
	logic [fbpa_pkg::SIZE_W-1:0] res_rsz;
	logic                        do_set;
	logic                        do_clr;
	logic [fbpa_pkg::CNT_W-1:0]  total_d;
	logic [fbpa_pkg::ADDR_W-1:0] res_addr_full;
	logic                        commit;

	fbpa_pkg::status_t            out_status_q;
	logic [fbpa_pkg::IDX_W-1:0]   out_idx_q;
	logic [fbpa_pkg::BADDR_W-1:0] out_addr_q;
	logic                         out_used_q;
	logic [fbpa_pkg::SIZE_W-1:0]  out_rsz_q;

	assign in_size = s_tdata[15:0];
	assign in_addr = s_tdata[31:16];
	assign in_null = s_tdata[32];

	assign s_tready = (state_q == fbpa_pkg::S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign commit   = (state_q == fbpa_pkg::S_EXEC) && (!m_tvalid || m_tready);

	// Address to block index: aligned and inside the pool
	assign addr_hi = in_addr[fbpa_pkg::ADDR_W-1:fbpa_pkg::OFS_W];
	always_comb begin
		map_idx    = addr_hi[fbpa_pkg::IDX_W-1:0];
		map_status = fbpa_pkg::ST_OK;
		priority if (in_null) begin
			map_status = fbpa_pkg::ST_NULL;
		end else if (in_addr[fbpa_pkg::OFS_W-1:0] != '0) begin
			map_status = fbpa_pkg::ST_BADADDR;
		end else if (addr_hi >= (fbpa_pkg::ADDR_W - fbpa_pkg::OFS_W)'(fbpa_pkg::BLOCK_COUNT)) begin
			map_status = fbpa_pkg::ST_BADADDR;
		end
	end

	fbpa_ram #(
		.WIDTH(fbpa_pkg::SIZE_W),
		.DEPTH(fbpa_pkg::BLOCK_COUNT)
	) u_size_ram (
		.clk  (clk),
		.we   (commit && do_set),
		.waddr(res_idx),
		.wdata(res_rsz),
		.re   (accept),
		.raddr(map_idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1       <= fbpa_pkg::req_type_t'(s_tuser);
			size_s1       <= in_size;
			map_status_s1 <= map_status;
			map_idx_s1    <= map_idx;
		end
	end

	// Lowest free block
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = fbpa_pkg::BLOCK_COUNT - 1; i >= 0; i--) begin
			if (!marks_q[i]) begin
				free_found = 1'b1;
				free_idx   = fbpa_pkg::IDX_W'(i);
			end
		end
	end

	always_comb begin
		res_status = fbpa_pkg::ST_OK;
		res_idx    = '0;
		res_named  = 1'b0;
		res_used   = 1'b0;
		res_rsz    = '0;
		do_set     = 1'b0;
		do_clr     = 1'b0;
		total_d    = total_q;
		unique case (type_s1)
			fbpa_pkg::REQ_ALLOC: begin
				priority if (size_s1 == '0) begin
					res_status = fbpa_pkg::ST_ZERO;
				end else if (size_s1 > fbpa_pkg::REQ_SIZE_W'(fbpa_pkg::BLOCK_BYTES)) begin
					res_status = fbpa_pkg::ST_LARGE;
				end else if (!free_found) begin
					res_status = fbpa_pkg::ST_FULL;
				end else begin
					res_idx   = free_idx;
					res_named = 1'b1;
					res_used  = 1'b1;
					res_rsz   = size_s1[fbpa_pkg::SIZE_W-1:0];
					do_set    = 1'b1;
					total_d   = total_q + 1'b1;
				end
			end
			fbpa_pkg::REQ_FREE, fbpa_pkg::REQ_QUERY: begin
				res_status = map_status_s1;
				if (map_status_s1 == fbpa_pkg::ST_OK) begin
					res_idx   = map_idx_s1;
					res_named = 1'b1;
					if (type_s1 == fbpa_pkg::REQ_FREE) begin
						if (!marks_q[map_idx_s1]) begin
							res_status = fbpa_pkg::ST_FREED;
						end else begin
							do_clr = 1'b1;
							if (total_q != '0) begin
								total_d = total_q - 1'b1;
							end
						end
					end else begin
						// a free block reads as size zero whatever the RAM holds
						res_used = marks_q[map_idx_s1];
						res_rsz  = marks_q[map_idx_s1] ? ram_rdata : '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign res_addr_full = fbpa_pkg::ADDR_W'(res_idx) << fbpa_pkg::OFS_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= fbpa_pkg::S_IDLE;
			marks_q  <= '0;
			total_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			unique case (state_q)
				fbpa_pkg::S_IDLE: begin
					if (accept) begin
						state_q <= fbpa_pkg::S_EXEC;
					end
				end
				fbpa_pkg::S_EXEC: begin
					if (commit) begin
						state_q <= fbpa_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= fbpa_pkg::S_IDLE;
				end
			endcase
			if (commit) begin
				total_q <= total_d;
				if (do_set) begin
					marks_q[res_idx] <= 1'b1;
				end
				if (do_clr) begin
					marks_q[res_idx] <= 1'b0;
				end
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_status_q <= res_status;
			out_idx_q    <= res_idx;
			out_addr_q   <= res_named ? res_addr_full[fbpa_pkg::BADDR_W-1:0] : '0;
			out_used_q   <= res_used;
			out_rsz_q    <= res_rsz;
		end
	end

	// the in-use count follows the committed total, which holds until the next commit
	assign m_tuser = out_status_q;
	assign m_tdata = {5'd0, total_q, out_rsz_q, out_used_q, out_addr_q, out_idx_q};

endmodule
